[rtl/lds_pkg.sv]
package lds_pkg;

    localparam int NUM_SHAPES = 4;
    localparam int MAX_WIDTH  = 1024;
    localparam int NUM_RAMPS  = 3;

    localparam logic [10:0] SCREEN_WIDTH_RST = 11'd320;

    // reciprocal shift of the rad divider, numerators stay below 2^DIV_SH
    localparam int DIV_SH = 19;

    // x / 100 as (x * RECIP100) >> RECIP100_SH, exact for |x| < 2^13
    localparam logic [13:0] RECIP100    = 14'd10486;
    localparam int          RECIP100_SH = 20;

    typedef logic signed [20:0] t_num;
    typedef logic signed [18:0] t_quo;

    localparam logic signed [5:0] BUMP_ROM [64] = '{
        6'sd12, -6'sd9, 6'sd18, 6'sd4, -6'sd16, 6'sd10, 6'sd21, -6'sd5,
        6'sd14, -6'sd18, 6'sd6, 6'sd16, -6'sd11, 6'sd2, 6'sd20, -6'sd7,
        -6'sd14, 6'sd10, 6'sd22, -6'sd6, 6'sd8, -6'sd18, 6'sd5, 6'sd16,
        -6'sd12, 6'sd20, 6'sd2, -6'sd8, 6'sd15, 6'sd6, -6'sd16, 6'sd12,
        6'sd20, 6'sd4, -6'sd13, 6'sd16, -6'sd2, 6'sd12, -6'sd20, 6'sd9,
        6'sd18, -6'sd7, -6'sd15, 6'sd11, 6'sd4, 6'sd22, -6'sd10, 6'sd0,
        -6'sd5, 6'sd17, 6'sd8, -6'sd19, 6'sd12, 6'sd3, -6'sd11, 6'sd23,
        6'sd7, -6'sd14, 6'sd18, -6'sd3, 6'sd10, 6'sd15, -6'sd9, 6'sd5
    };

    typedef struct packed {
        logic signed [11:0] cx;
        logic signed [12:0] dy;
        logic [7:0]         rad;
        logic [7:0]         rot;
        logic [1:0]         shape;
        logic [1:0]         kind;
        logic               hit;
        logic [16:0]        t;
        logic [8:0]         w;
        logic [7:0]         ang_l;
        logic [7:0]         ang_r;
        logic signed [7:0]  pro_l;
        logic signed [7:0]  pro_r;
        logic signed [16:0] prod_l;
        logic signed [16:0] prod_r;
        logic signed [13:0] xl;
        logic signed [13:0] xr;
        logic [9:0]         cl;
        logic [9:0]         cr;
        logic               rl_ok;
        logic               rr_ok;
        t_quo               dyq;
        logic signed [14:0] db;
    } t_ctx;

    typedef struct packed {
        logic [1:0]         ramp_sel;
        logic [2:0]         right_rim_index;
        logic [9:0]         right_rim_x;
        logic               right_rim_valid;
        logic [2:0]         left_rim_index;
        logic [9:0]         left_rim_x;
        logic               left_rim_valid;
        logic signed [14:0] brightness_step;
        logic signed [17:0] start_brightness;
        logic [9:0]         fill_end;
        logic [9:0]         fill_start;
        logic               row_hit;
    } t_res;

endpackage

[rtl/lds_div.sv]
module lds_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  lds_pkg::t_num i_num,
    input  logic [7:0]    i_den,
    output lds_pkg::t_quo o_quo
);
    import lds_pkg::*;

    logic [18:0] w_rc [256];

    for (genvar g = 0; g < 256; g++) begin : g_rc
        localparam logic [18:0] RC =
            (g < 2) ? 19'd0 : 19'((1 << DIV_SH) / ((g < 2) ? 1 : g));
        assign w_rc[g] = RC;
    end

    logic [18:0] w_mag;
    logic [37:0] w_prod;
    logic [18:0] r_q0;
    logic [18:0] r_mag;
    logic [7:0]  r_den;
    logic        r_neg;
    logic [26:0] w_qd;
    logic [26:0] w_rem;
    logic [18:0] w_q;
    t_quo        r_quo;

    assign w_mag  = i_num[20] ? 19'(-i_num) : 19'(i_num);
    assign w_prod = w_mag * w_rc[i_den];

    // estimate is exact or one low
    assign w_qd  = r_q0 * r_den;
    assign w_rem = {8'b0, r_mag} - w_qd;
    assign w_q   = (w_rem >= {19'b0, r_den}) ? r_q0 + 19'd1 : r_q0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0  <= w_prod[37:19];
            r_mag <= w_mag;
            r_den <= i_den;
            r_neg <= i_num[20];
            r_quo <= r_neg ? t_quo'(-w_q) : t_quo'(w_q);
        end
    end

    assign o_quo = r_quo;

endmodule

[rtl/lds_isqrt.sv]
module lds_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_t,
    output logic [8:0]  o_w
);
    import lds_pkg::*;

    // three result bits per stage, {rem, root}
    function automatic logic [25:0] sq3(input logic [16:0] rem_in,
                                        input logic [8:0] root_in,
                                        input int top);
        logic [19:0] rem;
        logic [19:0] root;
        logic [19:0] test;
        rem  = {3'b0, rem_in};
        root = {11'b0, root_in};
        for (int k = 0; k < 3; k++) begin
            test = (root << (top - k + 1)) + (20'd1 << (2 * (top - k)));
            if (rem >= test) begin
                rem  = rem - test;
                root = root | (20'd1 << (top - k));
            end
        end
        return {rem[16:0], root[8:0]};
    endfunction

    logic [25:0] r_s0;
    logic [25:0] r_s1;
    logic [25:0] r_s2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= sq3(i_t, 9'd0, 8);
            r_s1 <= sq3(r_s0[25:9], r_s0[8:0], 5);
            r_s2 <= sq3(r_s1[25:9], r_s1[8:0], 2);
        end
    end

    assign o_w = r_s2[8:0];

endmodule

[rtl/lds_prof.sv]
module lds_prof (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [1:0]        i_shape,
    input  logic [7:0]        i_ang_l,
    input  logic [7:0]        i_ang_r,
    output logic signed [7:0] o_pro_l,
    output logic signed [7:0] o_pro_r
);
    import lds_pkg::*;

    function automatic logic signed [7:0] bump_at(input logic [1:0] shape,
                                                  input logic [7:0] ang);
        logic [3:0]         i1;
        logic signed [6:0]  v0;
        logic signed [6:0]  v1;
        logic signed [6:0]  dif;
        logic signed [11:0] prd;
        i1  = ang[7:4] + 4'd1;
        v0  = 7'(BUMP_ROM[{shape, ang[7:4]}]);
        v1  = 7'(BUMP_ROM[{shape, i1}]);
        dif = v1 - v0;
        prd = dif * $signed({1'b0, ang[3:0]});
        return 8'(v0) + 8'(prd >>> 4);
    endfunction

    function automatic logic signed [7:0] profile(input logic [1:0] shape,
                                                  input logic [7:0] ang);
        logic [1:0] nxt;
        logic [7:0] ang3;
        nxt  = (shape + 2'd1) & 2'(NUM_SHAPES - 1);
        ang3 = ang + {ang[6:0], 1'b0};
        return bump_at(shape, ang) + (bump_at(nxt, ang3) >>> 2);
    endfunction

    logic signed [7:0] r_pro_l;
    logic signed [7:0] r_pro_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pro_l <= profile(i_shape, i_ang_l);
            r_pro_r <= profile(i_shape, i_ang_r);
        end
    end

    assign o_pro_l = r_pro_l;
    assign o_pro_r = r_pro_r;

endmodule

[rtl/lumpy_disc_scanline_span.sv]
// Scanline span engine for lumpy, lit rocks.
// Slave stream: one request per rock row. tdata carries center_x, center_y,
// radius, rotation and row; tuser carries shape_sel and material.
// Master stream: one span descriptor per request. tuser carries row_hit and
// ramp_sel; tdata carries fill range, Q8 brightness start and step, and both
// rims with valid bit, column and darkened ramp index.
// i_cfg_we/i_cfg_wdata write screen_width; write it only while the block is
// empty.
// Throughput: one request per clock while the output is not stalled. The
// request is registered on acceptance, then passes ten more stages (rad
// dividers, a three-stage square root, bump profile, clip, rim dividers) and
// the output register before m_axis_tvalid.
// Reset clears all valid bits and sets screen_width to 320.
// When m_axis_tready is low the result is held, one more result is taken
// into a spare register, and then s_axis_tready drops and the whole pipeline
// freezes until the output is taken; nothing is lost or repeated.
module lumpy_disc_scanline_span (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // center_x[11:0], center_y[23:12], radius[31:24], rotation[39:32], row[51:40]
    input  logic [55:0] s_axis_tdata,
    // shape_sel[1:0], material[3:2]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fill_start[9:0], fill_end[19:10], start_brightness[37:20],
    // brightness_step[52:38], left_rim_valid[53], left_rim_x[63:54],
    // left_rim_index[66:64], right_rim_valid[67], right_rim_x[77:68],
    // right_rim_index[80:78]
    output logic [87:0] m_axis_tdata,
    // row_hit[0], ramp_sel[2:1]
    output logic [2:0]  m_axis_tuser
);
    import lds_pkg::*;

    localparam int NS = 11;

    function automatic logic signed [13:0] div100(input logic signed [16:0] p);
        logic [12:0] mag;
        logic [26:0] q;
        mag = p[16] ? 13'(-p) : p[12:0];
        q   = (mag * RECIP100) >> RECIP100_SH;
        return p[16] ? -14'(q[12:0]) : 14'(q[12:0]);
    endfunction

    function automatic logic [2:0] rim_idx(input t_num v);
        logic [7:0] c;
        if (v < 0) begin
            c = 8'd0;
        end else if (v > 21'sd255) begin
            c = 8'd255;
        end else begin
            c = v[7:0];
        end
        return (c[7:5] >= 3'd3) ? c[7:5] - 3'd3 : 3'd0;
    endfunction

    logic [10:0] r_sw;
    t_ctx        r_ctx [1:NS];
    t_ctx        n_ctx [1:NS];
    logic        r_vld [1:NS];
    logic        w_en;

    t_res r_out;
    t_res r_spare;
    logic r_ov;
    logic r_sv;
    t_res w_res;
    logic w_push;
    logic w_pop;

    // front end dividers and square root
    t_num        w_na;
    t_num        w_nb;
    t_quo        w_qa;
    t_quo        w_qb;
    t_quo        w_qc;
    logic [8:0]  w_root;
    logic signed [7:0] w_pro_l;
    logic signed [7:0] w_pro_r;

    // back end dividers
    t_num w_nd;
    t_num w_ne;
    t_num w_nf;
    t_quo w_qd;
    t_quo w_qe;
    t_quo w_qf;

    logic [15:0]        w_rr;
    logic signed [25:0] w_dy2;
    logic signed [25:0] w_t;
    logic [10:0]        w_gw;
    logic signed [11:0] w_gw1;
    logic signed [13:0] w_cl;
    logic signed [13:0] w_cr;
    t_num               w_vb;
    t_num               w_vl;
    t_num               w_vr;

    assign w_en          = !r_sv;
    assign s_axis_tready = w_en;

    assign w_rr  = r_ctx[1].rad * r_ctx[1].rad;
    assign w_dy2 = r_ctx[1].dy * r_ctx[1].dy;
    assign w_t   = $signed({10'b0, w_rr}) - w_dy2;
    assign w_na  = t_num'(r_ctx[1].dy) <<< 6;
    assign w_nb  = t_num'(r_ctx[1].dy) * t_num'(100);

    lds_div u_div_ar (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_na), .i_den(r_ctx[1].rad), .o_quo(w_qa)
    );
    lds_div u_div_dy (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nb), .i_den(r_ctx[1].rad), .o_quo(w_qb)
    );
    lds_div u_div_step (
        .i_clk(i_clk), .i_en(w_en), .i_num(t_num'(-25600)), .i_den(r_ctx[1].rad),
        .o_quo(w_qc)
    );

    lds_isqrt u_isqrt (
        .i_clk(i_clk), .i_en(w_en), .i_t(r_ctx[2].t), .o_w(w_root)
    );

    lds_prof u_prof (
        .i_clk(i_clk), .i_en(w_en), .i_shape(r_ctx[4].shape),
        .i_ang_l(r_ctx[4].ang_l), .i_ang_r(r_ctx[4].ang_r),
        .o_pro_l(w_pro_l), .o_pro_r(w_pro_r)
    );

    assign w_gw  = (r_sw > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_sw;
    assign w_gw1 = $signed({1'b0, w_gw}) - 12'sd1;
    assign w_cl  = (r_ctx[8].xl < 0) ? 14'sd0 : r_ctx[8].xl;
    assign w_cr  = (r_ctx[8].xr > 14'(w_gw1)) ? 14'(w_gw1) : r_ctx[8].xr;

    assign w_nd = (t_num'($signed({1'b0, r_ctx[9].cl})) - t_num'(r_ctx[9].cx))
                  * t_num'(100);
    assign w_ne = (t_num'(r_ctx[9].xl) - t_num'(r_ctx[9].cx)) * t_num'(100);
    assign w_nf = (t_num'(r_ctx[9].xr) - t_num'(r_ctx[9].cx)) * t_num'(100);

    lds_div u_div_b (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nd), .i_den(r_ctx[9].rad), .o_quo(w_qd)
    );
    lds_div u_div_rl (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_ne), .i_den(r_ctx[9].rad), .o_quo(w_qe)
    );
    lds_div u_div_rr (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_nf), .i_den(r_ctx[9].rad), .o_quo(w_qf)
    );

    always_comb begin
        n_ctx[1]       = '0;
        n_ctx[1].cx    = s_axis_tdata[11:0];
        n_ctx[1].dy    = 13'($signed(s_axis_tdata[51:40]))
                         - 13'($signed(s_axis_tdata[23:12]));
        n_ctx[1].rad   = s_axis_tdata[31:24];
        n_ctx[1].rot   = s_axis_tdata[39:32];
        n_ctx[1].shape = s_axis_tuser[1:0] & 2'(NUM_SHAPES - 1);
        n_ctx[1].kind  = (s_axis_tuser[3:2] >= 2'(NUM_RAMPS)) ? 2'd0 : s_axis_tuser[3:2];

        for (int k = 2; k <= NS; k++) begin
            n_ctx[k] = r_ctx[k - 1];
        end

        n_ctx[2].hit = (r_ctx[1].rad >= 8'd2) && (w_t > 0);
        n_ctx[2].t   = w_t[16:0];

        n_ctx[4].ang_l = 8'd128 - w_qa[7:0] + r_ctx[3].rot;
        n_ctx[4].ang_r = w_qa[7:0] + r_ctx[3].rot;
        n_ctx[4].dyq   = w_qb;
        n_ctx[4].db    = w_qc[14:0];

        n_ctx[6].w     = w_root;
        n_ctx[6].pro_l = w_pro_l;
        n_ctx[6].pro_r = w_pro_r;

        n_ctx[7].prod_l = $signed({1'b0, r_ctx[6].w}) * r_ctx[6].pro_l;
        n_ctx[7].prod_r = $signed({1'b0, r_ctx[6].w}) * r_ctx[6].pro_r;

        n_ctx[8].xl = 14'(r_ctx[7].cx) - $signed({5'b0, r_ctx[7].w})
                      - div100(r_ctx[7].prod_l);
        n_ctx[8].xr = 14'(r_ctx[7].cx) + $signed({5'b0, r_ctx[7].w})
                      + div100(r_ctx[7].prod_r);

        n_ctx[9].hit   = r_ctx[8].hit && (r_ctx[8].xr >= r_ctx[8].xl) && (w_cl <= w_cr);
        n_ctx[9].cl    = w_cl[9:0];
        n_ctx[9].cr    = w_cr[9:0];
        n_ctx[9].rl_ok = (r_ctx[8].xl >= 0) && (r_ctx[8].xl < $signed({3'b0, w_gw}));
        n_ctx[9].rr_ok = (r_ctx[8].xr >= 0) && (r_ctx[8].xr < $signed({3'b0, w_gw}));
    end

    assign w_vb = t_num'(128) - t_num'(w_qd) - t_num'(r_ctx[11].dyq);
    assign w_vl = t_num'(128) - t_num'(w_qe) - t_num'(r_ctx[11].dyq);
    assign w_vr = t_num'(128) - t_num'(w_qf) - t_num'(r_ctx[11].dyq);

    always_comb begin
        w_res          = '0;
        w_res.ramp_sel = r_ctx[11].kind;
        if (r_ctx[11].hit) begin
            w_res.row_hit          = 1'b1;
            w_res.fill_start       = r_ctx[11].cl;
            w_res.fill_end         = r_ctx[11].cr;
            w_res.start_brightness = {w_vb[9:0], 8'b0};
            w_res.brightness_step  = r_ctx[11].db;
            if (r_ctx[11].rl_ok) begin
                w_res.left_rim_valid = 1'b1;
                w_res.left_rim_x     = r_ctx[11].xl[9:0];
                w_res.left_rim_index = rim_idx(w_vl);
            end
            if (r_ctx[11].rr_ok) begin
                w_res.right_rim_valid = 1'b1;
                w_res.right_rim_x     = r_ctx[11].xr[9:0];
                w_res.right_rim_index = rim_idx(w_vr);
            end
        end
    end

    assign w_push = w_en && r_vld[NS];
    assign w_pop  = r_ov && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SCREEN_WIDTH_RST;
            for (int k = 1; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sw <= i_cfg_wdata;
            end
            if (w_en) begin
                r_vld[1] <= s_axis_tvalid;
                for (int k = 2; k <= NS; k++) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
            if (r_sv) begin
                if (w_pop) begin
                    r_sv <= 1'b0;
                end
            end else if (w_push) begin
                if (r_ov && !w_pop) begin
                    r_sv <= 1'b1;
                end
                r_ov <= 1'b1;
            end else if (w_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k <= NS; k++) begin
                r_ctx[k] <= n_ctx[k];
            end
        end
        if (r_sv) begin
            if (w_pop) begin
                r_out <= r_spare;
            end
        end else if (w_push) begin
            if (!r_ov || w_pop) begin
                r_out <= w_res;
            end else begin
                r_spare <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = {r_out.ramp_sel, r_out.row_hit};
    assign m_axis_tdata  = {7'b0,
                            r_out.right_rim_index, r_out.right_rim_x, r_out.right_rim_valid,
                            r_out.left_rim_index, r_out.left_rim_x, r_out.left_rim_valid,
                            r_out.brightness_step, r_out.start_brightness,
                            r_out.fill_end, r_out.fill_start};

endmodule
